// File: rtl/cdq_pkg.sv
`default_nettype none

package cdq_pkg;

  // operation codes carried on the input tuser
  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_e;

  // result status codes carried on the output tuser
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2
  } status_e;

  localparam int unsigned ValueWidth   = 32;
  localparam int unsigned OutDataWidth = 40;

endpackage

`default_nettype wire

// File: rtl/cdq_ram.sv
`default_nettype none

module cdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/circular_deque_engine_core.sv
`default_nettype none

// double-ended queue of DEPTH signed 32-bit entries in a circular ram
// input stream: s_axis_tuser carries the operation (push front, push back,
//   pop front, pop back), s_axis_tdata the value to push (ignored on pops)
// output stream: one result transfer per input transfer, in order;
//   tdata holds the popped value and the empty/full flags after the
//   operation, tuser the status (ok, overflow, underflow)
// a push or a rejected operation is registered straight into the output
//   register; a pop that returns data is read first into the registered
//   read port of the slot ram, then moved into the output register
// pushes and rejects pass at one item per cycle while results are taken; a
//   pop with data blocks input until its result is in the output register;
//   a new input is taken while the previous result waits, as long as the output register is taken in that cycle
// a push to a full deque leaves it unchanged and reports overflow; a pop
//   from an empty deque reports underflow with a zero value
// reset: the deque comes up empty with both pointers at slot zero; the ram
//   itself is not cleared and no slot is read before it is written
// receiver stall: the result stays in the output register and
//   s_axis_tready drops until it is taken
module circular_deque_engine_core #(
  parameter int unsigned DEPTH = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // push_value[31:0]
  input  wire logic [1:0]  s_axis_tuser,   // cmd[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [cdq_pkg::OutDataWidth-1:0] m_axis_tdata, // pop_value[31:0], is_empty, is_full,
                                                         // zero pad
  output logic [1:0]       m_axis_tuser    // status[1:0]
);

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

  state_e state_q;

  // pointers and empty marker
  logic [IdxW-1:0] head_q, head_d;
  logic [IdxW-1:0] tail_q, tail_d;
  logic            empty_q, empty_d;

  // output register
  logic                                  out_valid_q;
  logic signed [cdq_pkg::ValueWidth-1:0] pop_value_q;
  cdq_pkg::status_e                      status_q;
  logic                                  is_empty_q;
  logic                                  is_full_q;

  // ram access
  logic                           ram_we;
  logic [IdxW-1:0]                ram_waddr;
  logic                           ram_re;
  logic [IdxW-1:0]                ram_raddr;
  logic [cdq_pkg::ValueWidth-1:0] ram_rdata;

  cdq_pkg::cmd_e    cmd;
  cdq_pkg::status_e status_d;
  logic             in_xfer;
  logic             is_push;
  logic             full_now;
  logic             full_next;
  logic             need_read;

  function automatic logic [IdxW-1:0] wrap_inc(input logic [IdxW-1:0] i);
    wrap_inc = (i == LastIdx) ? '0 : i + IdxW'(1);
  endfunction

  function automatic logic [IdxW-1:0] wrap_dec(input logic [IdxW-1:0] i);
    wrap_dec = (i == '0) ? LastIdx : i - IdxW'(1);
  endfunction

  assign cmd     = cdq_pkg::cmd_e'(s_axis_tuser);
  assign is_push = (cmd == cdq_pkg::CMD_PUSH_FRONT) || (cmd == cdq_pkg::CMD_PUSH_BACK);

  // one item in flight: new input only when idle and the output slot frees up
  assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  assign full_now = !empty_q && (wrap_inc(tail_q) == head_q);

  // next pointer state and slot access for the accepted operation
  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    empty_d   = empty_q;
    status_d  = cdq_pkg::STAT_OK;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_re    = 1'b0;
    ram_raddr = head_q;
    need_read = 1'b0;
    if (in_xfer) begin
      if (is_push) begin
        if (full_now) begin
          status_d = cdq_pkg::STAT_OVERFLOW;
        end else if (empty_q) begin
          // first entry always lands in slot zero
          head_d    = '0;
          tail_d    = '0;
          empty_d   = 1'b0;
          ram_we    = 1'b1;
          ram_waddr = '0;
        end else if (cmd == cdq_pkg::CMD_PUSH_FRONT) begin
          head_d    = wrap_dec(head_q);
          ram_we    = 1'b1;
          ram_waddr = wrap_dec(head_q);
        end else begin
          tail_d    = wrap_inc(tail_q);
          ram_we    = 1'b1;
          ram_waddr = wrap_inc(tail_q);
        end
      end else begin
        if (empty_q) begin
          status_d = cdq_pkg::STAT_UNDERFLOW;
        end else begin
          need_read = 1'b1;
          ram_re    = 1'b1;
          ram_raddr = (cmd == cdq_pkg::CMD_POP_FRONT) ? head_q : tail_q;
          if (head_q == tail_q) begin
            // last entry leaves, pointers go home
            head_d  = '0;
            tail_d  = '0;
            empty_d = 1'b1;
          end else if (cmd == cdq_pkg::CMD_POP_FRONT) begin
            head_d = wrap_inc(head_q);
          end else begin
            tail_d = wrap_dec(tail_q);
          end
        end
      end
    end
  end

  assign full_next = !empty_d && (wrap_inc(tail_d) == head_d);

  cdq_ram #(
    .WIDTH (cdq_pkg::ValueWidth),
    .DEPTH (DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (s_axis_tdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // control state, pointers and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      empty_q     <= 1'b1;
      out_valid_q <= 1'b0;
      pop_value_q <= '0;
      status_q    <= cdq_pkg::STAT_OK;
      is_empty_q  <= 1'b1;
      is_full_q   <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      empty_q <= empty_d;
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer && !need_read) begin
            out_valid_q <= 1'b1;
            pop_value_q <= '0;
            status_q    <= status_d;
            is_empty_q  <= empty_d;
            is_full_q   <= full_next;
          end else begin
            // held result leaves once the receiver takes it
            if (out_valid_q && m_axis_tready) begin
              out_valid_q <= 1'b0;
            end
            if (in_xfer) begin
              // result waits for the ram read
              state_q <= ST_READ;
            end
          end
        end
        ST_READ: begin
          // pointers already moved, flags come from the updated state
          state_q     <= ST_IDLE;
          out_valid_q <= 1'b1;
          pop_value_q <= ram_rdata;
          status_q    <= cdq_pkg::STAT_OK;
          is_empty_q  <= empty_q;
          is_full_q   <= full_now;
        end
        default: begin
          state_q     <= ST_IDLE;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, is_full_q, is_empty_q, pop_value_q};
  assign m_axis_tuser  = status_q;

`ifndef ASSERT_OFF
  // an empty deque always has both pointers parked at slot zero
  a_empty_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_q |-> (head_q == '0) && (tail_q == '0))
    else $error("empty deque with pointers away from slot zero");

  // the output register is free while a pop read is pending
  a_read_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> !out_valid_q)
    else $error("pending pop read collides with a held result");

  // a pop that returns data goes through the read state
  a_pop_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && !is_push && !empty_q) |=> (state_q == ST_READ))
    else $error("pop with data did not wait for the ram read");

  // underflow only ever reported on an empty deque
  a_underflow_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q == cdq_pkg::STAT_UNDERFLOW)) |-> is_empty_q)
    else $error("underflow reported while deque holds entries");

  // overflow only ever reported on a full deque
  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q == cdq_pkg::STAT_OVERFLOW)) |-> is_full_q)
    else $error("overflow reported while deque has room");
`endif

endmodule

`default_nettype wire

// File: tb/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = 8;

  // one result as the deque reports it
  typedef struct packed {
    logic [31:0]      pop_value;
    cdq_pkg::status_e status;
    logic             is_empty;
    logic             is_full;
  } deque_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // push_value[31:0]
  logic [1:0]  s_axis_tuser = '0;   // cmd[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // pop_value[31:0], is_empty, is_full, zero pad
  logic [1:0]  m_axis_tuser;        // status[1:0]

  // shadow copy of the deque contents and pointers
  logic [31:0] shadow_slots [DEPTH];
  int unsigned shadow_head = 0;
  int unsigned shadow_tail = 0;
  bit          shadow_empty = 1'b1;

  deque_result_t pending_results [$];

  // knobs shared between the test sequence and the handshake processes
  bit idling_on = 1'b1;
  int hold_serial = 0;
  int hold_len = 0;

  int error_count = 0;
  int checked_count = 0;
  int pushes_stored = 0;
  int pops_with_data = 0;
  int overflow_count = 0;
  int underflow_count = 0;
  int full_seen = 0;

  circular_deque_engine_core #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic bit shadow_full();
    return !shadow_empty && ((shadow_tail + 1) % DEPTH) == shadow_head;
  endfunction

  // apply one operation to the shadow deque and return what the block must report
  function automatic deque_result_t apply_deque_op(cdq_pkg::cmd_e op, logic [31:0] value);
    deque_result_t res;
    int unsigned   slot;
    res.pop_value = '0;
    res.status    = cdq_pkg::STAT_OK;
    if (op == cdq_pkg::CMD_PUSH_FRONT || op == cdq_pkg::CMD_PUSH_BACK) begin
      if (shadow_full()) begin
        res.status = cdq_pkg::STAT_OVERFLOW;
      end else if (shadow_empty) begin
        // first entry always lands in slot zero
        shadow_head     = 0;
        shadow_tail     = 0;
        shadow_slots[0] = value;
        shadow_empty    = 1'b0;
      end else if (op == cdq_pkg::CMD_PUSH_FRONT) begin
        shadow_head = (shadow_head == 0) ? DEPTH - 1 : shadow_head - 1;
        shadow_slots[shadow_head] = value;
      end else begin
        shadow_tail = (shadow_tail + 1) % DEPTH;
        shadow_slots[shadow_tail] = value;
      end
    end else begin
      if (shadow_empty) begin
        res.status = cdq_pkg::STAT_UNDERFLOW;
      end else begin
        slot = (op == cdq_pkg::CMD_POP_FRONT) ? shadow_head : shadow_tail;
        res.pop_value = shadow_slots[slot];
        if (shadow_head == shadow_tail) begin
          // last entry gone, pointers go home
          shadow_head  = 0;
          shadow_tail  = 0;
          shadow_empty = 1'b1;
        end else if (op == cdq_pkg::CMD_POP_FRONT) begin
          shadow_head = (shadow_head + 1) % DEPTH;
        end else begin
          shadow_tail = (shadow_tail == 0) ? DEPTH - 1 : shadow_tail - 1;
        end
      end
    end
    res.is_empty = shadow_empty;
    res.is_full  = shadow_full();
    return res;
  endfunction

  // mostly random words, now and then an extreme
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // offer one operation and wait for its transfer; tvalid stays high afterwards
  task automatic send_op(cdq_pkg::cmd_e op, logic [31:0] value);
    deque_result_t res;
    int            gap;
    @(negedge clk_i);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    res = apply_deque_op(op, value);
    pending_results.push_back(res);
    case (res.status)
      cdq_pkg::STAT_OVERFLOW:  overflow_count++;
      cdq_pkg::STAT_UNDERFLOW: underflow_count++;
      default: begin
        if (op == cdq_pkg::CMD_PUSH_FRONT || op == cdq_pkg::CMD_PUSH_BACK) pushes_stored++;
        else pops_with_data++;
      end
    endcase
    if (res.is_full) full_seen++;
  endtask

  // pushes with probability push_pct, front or back at random
  task automatic send_random_op(int push_pct);
    cdq_pkg::cmd_e op;
    if ($urandom_range(1, 100) <= push_pct)
      op = $urandom_range(0, 1) ? cdq_pkg::CMD_PUSH_BACK : cdq_pkg::CMD_PUSH_FRONT;
    else
      op = $urandom_range(0, 1) ? cdq_pkg::CMD_POP_BACK : cdq_pkg::CMD_POP_FRONT;
    send_op(op, pick_value());
  endtask

  // receiver: random stall bursts, plus long hold-offs on request
  initial begin : result_sink
    int hold_seen;
    int hold_left;
    int stall;
    hold_seen = 0;
    forever begin
      @(negedge clk_i);
      if (hold_serial != hold_seen) begin
        hold_seen = hold_serial;
        m_axis_tready <= 1'b0;
        hold_left = hold_len;
        while (hold_left > 1) begin
          @(negedge clk_i);
          hold_left--;
        end
      end else if (idling_on && rst_ni && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 9);
        m_axis_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin
    deque_result_t want;
    deque_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.pop_value = m_axis_tdata[31:0];
      got.is_empty  = m_axis_tdata[32];
      got.is_full   = m_axis_tdata[33];
      got.status    = cdq_pkg::status_e'(m_axis_tuser);
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: result with nothing expected: value %h status %0d empty %b full %b",
                 $realtime, got.pop_value, got.status, got.is_empty, got.is_full);
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        if (got.pop_value !== want.pop_value) begin
          error_count++;
          $display("%0t: pop_value expected %h actual %h",
                   $realtime, want.pop_value, got.pop_value);
        end
        if (got.status !== want.status) begin
          error_count++;
          $display("%0t: status expected %0d actual %0d", $realtime, want.status, got.status);
        end
        if (got.is_empty !== want.is_empty) begin
          error_count++;
          $display("%0t: is_empty expected %b actual %b",
                   $realtime, want.is_empty, got.is_empty);
        end
        if (got.is_full !== want.is_full) begin
          error_count++;
          $display("%0t: is_full expected %b actual %b", $realtime, want.is_full, got.is_full);
        end
      end
    end
  end

  // underflow on empty, extremes, fill to full, overflow both ways, drain to empty
  task automatic test_directed_edges();
    int i;
    send_op(cdq_pkg::CMD_POP_FRONT,  32'h0000_0000);
    send_op(cdq_pkg::CMD_POP_BACK,   32'hffff_ffff);
    send_op(cdq_pkg::CMD_PUSH_FRONT, 32'h8000_0000);
    send_op(cdq_pkg::CMD_POP_BACK,   32'h0000_0000);   // pop of the only entry
    send_op(cdq_pkg::CMD_PUSH_BACK,  32'h7fff_ffff);
    send_op(cdq_pkg::CMD_PUSH_FRONT, 32'hffff_ffff);   // head wraps below slot zero
    send_op(cdq_pkg::CMD_PUSH_FRONT, 32'h0000_0000);
    send_op(cdq_pkg::CMD_POP_FRONT,  32'h1111_1111);
    send_op(cdq_pkg::CMD_PUSH_BACK,  32'h5555_5555);
    send_op(cdq_pkg::CMD_PUSH_BACK,  32'haaaa_aaaa);
    send_op(cdq_pkg::CMD_PUSH_FRONT, 32'h0000_0001);
    send_op(cdq_pkg::CMD_PUSH_BACK,  32'h1234_5678);
    send_op(cdq_pkg::CMD_PUSH_FRONT, 32'hdead_beef);
    send_op(cdq_pkg::CMD_PUSH_BACK,  32'h0f0f_0f0f);   // now full
    send_op(cdq_pkg::CMD_PUSH_FRONT, 32'h0000_0007);   // rejected
    send_op(cdq_pkg::CMD_PUSH_BACK,  32'h0000_0009);   // rejected
    send_op(cdq_pkg::CMD_POP_BACK,   32'h0000_0000);
    send_op(cdq_pkg::CMD_POP_FRONT,  32'h0000_0000);
    send_op(cdq_pkg::CMD_POP_FRONT,  32'h0000_0000);
    for (i = 0; i < 5; i++)
      send_op(i[0] ? cdq_pkg::CMD_POP_BACK : cdq_pkg::CMD_POP_FRONT, 32'h0000_0000);
    send_op(cdq_pkg::CMD_POP_FRONT,  32'h0000_0000);   // empty again
  endtask

  // receiver holds off for a long stretch while operations keep coming
  task automatic test_output_holdoff();
    int i;
    hold_len = 150;
    hold_serial++;
    for (i = 0; i < 40; i++) send_random_op(60);
  endtask

  // random walk whose push bias changes in segments, so full and empty both recur
  task automatic test_random_walk();
    int seg;
    int i;
    int bias;
    for (seg = 0; seg < 25; seg++) begin
      case ($urandom_range(0, 3))
        0: bias = 15;
        1: bias = 85;
        default: bias = 50;
      endcase
      for (i = 0; i < 24; i++) send_random_op(bias);
    end
  endtask

  // back-to-back operations with no idling
  task automatic test_back_to_back();
    int i;
    idling_on = 1'b0;
    for (i = 0; i < 150; i++) send_random_op((i / 30) % 2 ? 35 : 65);
  endtask

  initial begin : main_sequence
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_edges();
    test_output_holdoff();
    test_random_walk();
    test_back_to_back();

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    // wait on so that a stray extra result would still be caught
    repeat (8) @(posedge clk_i);

    $display("checked %0d results: %0d pushes stored, %0d pops with data, %0d full states",
             checked_count, pushes_stored, pops_with_data, full_seen);
    $display("rejected: %0d overflows, %0d underflows; one long output hold-off",
             overflow_count, underflow_count);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
